[rtl/core/sps_pkg.sv]
// ---------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the SPS header parser.
// ---------------------------------------------------------------------------
package sps_pkg;

   localparam int GOLOMB_MAX_ZEROS_DEF = 31;
   localparam int REQ_DEPTH_DEF        = 4;
   localparam int RSP_DEPTH_DEF        = 2;

   localparam logic [15:0] MAX_DIM_RESET = 16'd8192;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_BAD_CHR   = 3'd2;
   localparam logic [2:0] ST_BAD_POC   = 3'd3;
   localparam logic [2:0] ST_MANY_REF  = 3'd4;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd5;
   localparam logic [2:0] ST_BAD_CROP  = 3'd6;

   typedef struct packed {
      logic [7:0] rbsp_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  profile_code;
      logic [7:0]  level_code;
      logic [31:0] set_id;
      logic [1:0]  chroma_format;
      logic        frame_only;
      logic [15:0] pic_width;
      logic [15:0] pic_height;
   } rsp_type;

   function automatic logic is_high_profile(input logic [7:0] p);
      case (p) inside
         8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
         8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

endpackage

[rtl/core/sps_fifo.sv]
// ---------------------------------------------------------------------------
// sps_fifo
// Small register queue carrying one transaction type.
// ---------------------------------------------------------------------------
module sps_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/sps_bit_engine.sv]
// ---------------------------------------------------------------------------
// sps_bit_engine
// Bit-serial SPS syntax walker with Exp-Golomb decode and size derivation.
// ---------------------------------------------------------------------------
module sps_bit_engine #(
   parameter int GOLOMB_MAX_ZEROS = sps_pkg::GOLOMB_MAX_ZEROS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      max_dim,
   input  logic             in_valid,
   input  sps_pkg::req_type in_data,
   output logic             in_take,
   output logic             out_push,
   output sps_pkg::rsp_type out_data,
   input  logic             out_full
);
   import sps_pkg::*;

   localparam int GW = GOLOMB_MAX_ZEROS + 1;
   localparam int ZW = $clog2(GOLOMB_MAX_ZEROS + 2);

   typedef enum logic [5:0] {
      S_PROFILE, S_CONSTR, S_LEVEL, S_ID, S_CHROMA, S_SEP, S_DEPTH_L,
      S_DEPTH_C, S_BYPASS, S_SM_PRESENT, S_LIST_FLAG, S_LIST_DELTA,
      S_FRAMENUM, S_POC_TYPE, S_POC_LSB, S_POC_ZERO, S_POC_NONREF,
      S_POC_TB, S_POC_NUM, S_POC_OFF, S_MAXREF, S_GAPS, S_WIDTH,
      S_HEIGHT, S_FRAMEONLY, S_MBAFF, S_DIRECT, S_CROPFLAG, S_CROP0,
      S_CROP1, S_CROP2, S_CROP3, S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [7:0]    bits_ff, bits_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic          pend_ff, pend_in;
   logic [2:0]    fc_ff, fc_in;
   logic [7:0]    fix_ff, fix_in;
   logic [ZW-1:0] gz_ff, gz_in;
   logic          gs_ff, gs_in;
   logic [GW-1:0] gv_ff, gv_in;
   logic [3:0]    li_ff, li_in;
   logic [7:0]    ent_ff, ent_in;
   logic [7:0]    lsc_ff, lsc_in;
   logic [7:0]    nsc_ff, nsc_in;
   logic [2:0]    err_ff, err_in;
   logic [7:0]    prof_ff, prof_in;
   logic [7:0]    lev_ff, lev_in;
   logic [GW-1:0] id_ff, id_in;
   logic [1:0]    chr_ff, chr_in;
   logic          sep_ff, sep_in;
   logic          fonly_ff, fonly_in;
   logic [7:0]    nref_ff, nref_in;
   logic [GW-1:0] wm1_ff, wm1_in;
   logic [GW-1:0] hm1_ff, hm1_in;
   logic [15:0]   picw_ff, picw_in;
   logic [16:0]   pich_ff, pich_in;
   logic [GW-1:0] crop_ff [3];
   logic [GW-1:0] crop_in [3];

   logic          b, active, feed, emit;
   logic [ZW-1:0] gz_n;
   logic          gs_n, g_done, g_over, gol_en;
   logic [GW-1:0] gv_n, g_val;
   logic [7:0]    fix_n, sc_d, sc_next;
   logic [3:0]    li_inc;
   logic [7:0]    ent_inc;
   logic          fix_done;
   logic [11:0]   lim;
   logic [GW:0]   sumx, sumy;
   logic [GW+1:0] dx;
   logic [GW+2:0] dy;
   logic          sx, sy_c, crop_en, crop_bad, size_bad;
   logic [15:0]   wc;
   logic [16:0]   hc;
   logic [2:0]    status;

   assign b      = bits_ff[7];
   assign active = (cnt_ff != 4'd0);
   assign feed   = active && (err_ff == ST_OK) && (state_ff != S_DONE);
   assign emit   = pend_ff && !out_full;
   assign lim    = max_dim[15:4];

   always_comb begin
      g_done = 1'b0;
      g_over = 1'b0;
      gz_n   = gz_ff;
      gs_n   = gs_ff;
      gv_n   = gv_ff;
      g_val  = '0;
      if (!gs_ff) begin
         if (!b) begin
            gz_n   = gz_ff + ZW'(1);
            g_over = (gz_ff >= ZW'(GOLOMB_MAX_ZEROS));
         end else begin
            gs_n = 1'b1;
            gv_n = GW'(1);
            if (gz_ff == '0) begin
               g_done = 1'b1;
               gs_n   = 1'b0;
            end
         end
      end else begin
         gv_n = {gv_ff[GW-2:0], b};
         gz_n = gz_ff - ZW'(1);
         if (gz_ff == ZW'(1)) begin
            g_done = 1'b1;
            gs_n   = 1'b0;
            g_val  = gv_n - GW'(1);
         end
      end
   end

   assign fix_n    = {fix_ff[6:0], b};
   assign fix_done = (fc_ff == 3'd7);
   assign li_inc   = li_ff + 4'd1;
   assign ent_inc  = ent_ff + 8'd1;
   assign sc_d     = g_val[0] ? (g_val[8:1] + 8'd1) : (8'd0 - g_val[8:1]);
   assign sc_next  = lsc_ff + sc_d;

   always_comb begin
      crop_en = (state_ff == S_CROP3);
      sx      = !((chr_ff == 2'd0) || sep_ff || (chr_ff == 2'd3));
      sy_c    = !((chr_ff == 2'd0) || sep_ff) && (chr_ff == 2'd1);
      sumx    = {1'b0, crop_ff[0]} + {1'b0, crop_ff[1]};
      sumy    = {1'b0, crop_ff[2]} + {1'b0, g_val};
      dx      = {1'b0, sumx} << sx;
      dy      = {2'b0, sumy} << ({1'b0, sy_c} + {1'b0, !fonly_ff});
      crop_bad = crop_en && ((dx >= (GW+2)'(picw_ff)) || (dy >= (GW+3)'(pich_ff)));
      wc      = picw_ff - (crop_en ? dx[15:0] : 16'd0);
      hc      = pich_ff - (crop_en ? dy[16:0] : 17'd0);
      size_bad = (wc == 16'd0) || (hc == 17'd0) || (wc > max_dim) ||
                 (hc > {1'b0, max_dim});
   end

   always_comb begin
      state_in = state_ff;
      fc_in    = fc_ff;
      fix_in   = fix_ff;
      gz_in    = gz_ff;
      gs_in    = gs_ff;
      gv_in    = gv_ff;
      li_in    = li_ff;
      ent_in   = ent_ff;
      lsc_in   = lsc_ff;
      nsc_in   = nsc_ff;
      err_in   = err_ff;
      prof_in  = prof_ff;
      lev_in   = lev_ff;
      id_in    = id_ff;
      chr_in   = chr_ff;
      sep_in   = sep_ff;
      fonly_in = fonly_ff;
      nref_in  = nref_ff;
      wm1_in   = wm1_ff;
      hm1_in   = hm1_ff;
      picw_in  = picw_ff;
      pich_in  = pich_ff;
      crop_in  = crop_ff;
      gol_en   = 1'b0;
      if (feed) begin
         case (state_ff)
            S_PROFILE, S_CONSTR, S_LEVEL: begin
               fix_in = fix_n;
               fc_in  = fc_ff + 3'd1;
               if (fix_done) begin
                  if (state_ff == S_PROFILE) begin
                     prof_in  = fix_n;
                     state_in = S_CONSTR;
                  end else if (state_ff == S_CONSTR) begin
                     state_in = S_LEVEL;
                  end else begin
                     lev_in   = fix_n;
                     state_in = S_ID;
                  end
               end
            end
            S_ID: begin
               gol_en = 1'b1;
               if (g_done) begin
                  id_in    = g_val;
                  state_in = is_high_profile(prof_ff) ? S_CHROMA : S_FRAMENUM;
               end
            end
            S_CHROMA: begin
               gol_en = 1'b1;
               if (g_done) begin
                  if (g_val > GW'(3)) begin
                     err_in = ST_BAD_CHR;
                  end else begin
                     chr_in   = g_val[1:0];
                     state_in = (g_val[1:0] == 2'd3) ? S_SEP : S_DEPTH_L;
                  end
               end
            end
            S_SEP: begin
               sep_in   = b;
               state_in = S_DEPTH_L;
            end
            S_DEPTH_L: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_DEPTH_C;
            end
            S_DEPTH_C: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_BYPASS;
            end
            S_BYPASS: begin
               state_in = S_SM_PRESENT;
            end
            S_SM_PRESENT: begin
               li_in    = 4'd0;
               state_in = b ? S_LIST_FLAG : S_FRAMENUM;
            end
            S_LIST_FLAG: begin
               if (b) begin
                  ent_in   = 8'd0;
                  lsc_in   = 8'd8;
                  nsc_in   = 8'd8;
                  state_in = S_LIST_DELTA;
               end else begin
                  li_in    = li_inc;
                  state_in = (li_inc >= ((chr_ff != 2'd3) ? 4'd8 : 4'd12)) ?
                             S_FRAMENUM : S_LIST_FLAG;
               end
            end
            S_LIST_DELTA: begin
               gol_en = 1'b1;
               if (g_done) begin
                  nsc_in = sc_next;
                  if (sc_next != 8'd0) lsc_in = sc_next;
                  ent_in = ent_inc;
                  if ((ent_inc >= ((li_ff < 4'd6) ? 8'd16 : 8'd64)) ||
                      (sc_next == 8'd0)) begin
                     li_in    = li_inc;
                     state_in = (li_inc >= ((chr_ff != 2'd3) ? 4'd8 : 4'd12)) ?
                                S_FRAMENUM : S_LIST_FLAG;
                  end
               end
            end
            S_FRAMENUM: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_POC_TYPE;
            end
            S_POC_TYPE: begin
               gol_en = 1'b1;
               if (g_done) begin
                  if (g_val == GW'(0))      state_in = S_POC_LSB;
                  else if (g_val == GW'(1)) state_in = S_POC_ZERO;
                  else if (g_val == GW'(2)) state_in = S_MAXREF;
                  else                      err_in   = ST_BAD_POC;
               end
            end
            S_POC_LSB: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_MAXREF;
            end
            S_POC_ZERO: begin
               state_in = S_POC_NONREF;
            end
            S_POC_NONREF: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_POC_TB;
            end
            S_POC_TB: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_POC_NUM;
            end
            S_POC_NUM: begin
               gol_en = 1'b1;
               if (g_done) begin
                  if (g_val > GW'(255)) begin
                     err_in = ST_MANY_REF;
                  end else begin
                     nref_in  = g_val[7:0];
                     ent_in   = 8'd0;
                     state_in = (g_val[7:0] == 8'd0) ? S_MAXREF : S_POC_OFF;
                  end
               end
            end
            S_POC_OFF: begin
               gol_en = 1'b1;
               if (g_done) begin
                  ent_in = ent_inc;
                  if (ent_inc >= nref_ff) state_in = S_MAXREF;
               end
            end
            S_MAXREF: begin
               gol_en = 1'b1;
               if (g_done) state_in = S_GAPS;
            end
            S_GAPS: begin
               state_in = S_WIDTH;
            end
            S_WIDTH: begin
               gol_en = 1'b1;
               if (g_done) begin
                  wm1_in   = g_val;
                  state_in = S_HEIGHT;
               end
            end
            S_HEIGHT: begin
               gol_en = 1'b1;
               if (g_done) begin
                  hm1_in   = g_val;
                  state_in = S_FRAMEONLY;
               end
            end
            S_FRAMEONLY: begin
               fonly_in = b;
               state_in = b ? S_DIRECT : S_MBAFF;
            end
            S_MBAFF: begin
               state_in = S_DIRECT;
            end
            S_DIRECT: begin
               if ((wm1_ff >= GW'(lim)) || (hm1_ff >= GW'(lim))) begin
                  err_in = ST_BAD_SIZE;
               end else begin
                  picw_in  = {wm1_ff[11:0] + 12'd1, 4'b0};
                  pich_in  = fonly_ff ? {1'b0, hm1_ff[11:0] + 12'd1, 4'b0} :
                                        {hm1_ff[11:0] + 12'd1, 5'b0};
                  state_in = S_CROPFLAG;
               end
            end
            S_CROPFLAG, S_CROP3: begin
               if (state_ff == S_CROP3) gol_en = 1'b1;
               if ((state_ff == S_CROPFLAG) ? !b : g_done) begin
                  if (crop_bad) begin
                     err_in = ST_BAD_CROP;
                  end else begin
                     picw_in = wc;
                     pich_in = hc;
                     if (size_bad) err_in   = ST_BAD_SIZE;
                     else          state_in = S_DONE;
                  end
               end else if (state_ff == S_CROPFLAG) begin
                  state_in = S_CROP0;
               end
            end
            S_CROP0, S_CROP1, S_CROP2: begin
               gol_en = 1'b1;
               if (g_done) begin
                  if (state_ff == S_CROP0) begin
                     crop_in[0] = g_val;
                     state_in   = S_CROP1;
                  end else if (state_ff == S_CROP1) begin
                     crop_in[1] = g_val;
                     state_in   = S_CROP2;
                  end else begin
                     crop_in[2] = g_val;
                     state_in   = S_CROP3;
                  end
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
         if (gol_en) begin
            gz_in = gz_n;
            gs_in = gs_n;
            gv_in = gv_n;
            if (g_over) err_in = ST_TRUNC;
         end
      end
   end

   // byte sequencing
   logic byte_end;
   assign byte_end = active && (!feed || (cnt_ff == 4'd1));
   assign in_take  = in_valid &&
                     ((!active && !pend_ff) || (byte_end && !last_ff) || emit);

   always_comb begin
      bits_in = {bits_ff[6:0], 1'b0};
      cnt_in  = feed ? cnt_ff - 4'd1 : 4'd0;
      last_in = last_ff;
      pend_in = pend_ff;
      if (byte_end && last_ff) pend_in = 1'b1;
      if (emit) pend_in = 1'b0;
      if (in_take) begin
         bits_in = in_data.rbsp_byte;
         cnt_in  = 4'd8;
         last_in = in_data.last_byte;
      end
   end

   assign status = (err_ff != ST_OK) ? err_ff :
                   ((state_ff != S_DONE) ? ST_TRUNC : ST_OK);
   assign out_push = emit;

   always_comb begin
      out_data = '0;
      out_data.status = status;
      if (status == ST_OK) begin
         out_data.profile_code  = prof_ff;
         out_data.level_code    = lev_ff;
         out_data.set_id        = 32'(id_ff);
         out_data.chroma_format = chr_ff;
         out_data.frame_only    = fonly_ff;
         out_data.pic_width     = picw_ff;
         out_data.pic_height    = pich_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 4'd0;
         pend_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
         last_ff <= last_in;
      end
      bits_ff <= bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         state_ff <= S_PROFILE;
         fc_ff    <= 3'd0;
         fix_ff   <= 8'd0;
         gz_ff    <= '0;
         gs_ff    <= 1'b0;
         gv_ff    <= '0;
         li_ff    <= 4'd0;
         ent_ff   <= 8'd0;
         lsc_ff   <= 8'd8;
         nsc_ff   <= 8'd8;
         err_ff   <= ST_OK;
         prof_ff  <= 8'd0;
         lev_ff   <= 8'd0;
         id_ff    <= '0;
         chr_ff   <= 2'd1;
         sep_ff   <= 1'b0;
         fonly_ff <= 1'b0;
         nref_ff  <= 8'd0;
         wm1_ff   <= '0;
         hm1_ff   <= '0;
         picw_ff  <= 16'd0;
         pich_ff  <= 17'd0;
         crop_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         fix_ff   <= fix_in;
         gz_ff    <= gz_in;
         gs_ff    <= gs_in;
         gv_ff    <= gv_in;
         li_ff    <= li_in;
         ent_ff   <= ent_in;
         lsc_ff   <= lsc_in;
         nsc_ff   <= nsc_in;
         err_ff   <= err_in;
         prof_ff  <= prof_in;
         lev_ff   <= lev_in;
         id_ff    <= id_in;
         chr_ff   <= chr_in;
         sep_ff   <= sep_in;
         fonly_ff <= fonly_in;
         nref_ff  <= nref_in;
         wm1_ff   <= wm1_in;
         hm1_ff   <= hm1_in;
         picw_ff  <= picw_in;
         pich_ff  <= pich_in;
         crop_ff  <= crop_in;
      end
   end

endmodule

[rtl/core/h264_sps_header_parser_unit.sv]
// ---------------------------------------------------------------------------
// h264_sps_header_parser_unit
// H.264 SPS header parser: byte queue, bit-serial syntax engine, result queue.
// ---------------------------------------------------------------------------
// The bit engine shifts each SPS byte through one bit at a time and takes the
// next byte only once the current one is used up; once the syntax is complete
// or an error is flagged the rest of a byte is discarded, not shifted. The
// last byte's result waits for room in the output queue. Bytes are buffered
// in a REQ_DEPTH entry queue ahead of the engine and results in an RSP_DEPTH
// entry queue behind it, so push and pop stall independently of the engine.
module h264_sps_header_parser_unit #(
   parameter int GOLOMB_MAX_ZEROS = sps_pkg::GOLOMB_MAX_ZEROS_DEF,
   parameter int REQ_DEPTH        = sps_pkg::REQ_DEPTH_DEF,
   parameter int RSP_DEPTH        = sps_pkg::RSP_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sps_pkg::req_type req_data,
   output logic             full,
   input  logic             pop,
   output sps_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             csr_write,
   input  logic [15:0]      csr_wdata
);
   import sps_pkg::*;

   logic [15:0] max_dim_ff;
   logic        req_empty, req_take;
   req_type     req_head;
   logic        eng_push, rsp_full;
   rsp_type     eng_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dim_ff <= MAX_DIM_RESET;
      end else if (csr_write) begin
         max_dim_ff <= csr_wdata;
      end
   end

   sps_fifo #(.item_type(req_type), .DEPTH(REQ_DEPTH)) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (req_data),
      .full    (full),
      .rd_en   (req_take),
      .rd_data (req_head),
      .empty   (req_empty)
   );

   sps_bit_engine #(.GOLOMB_MAX_ZEROS(GOLOMB_MAX_ZEROS)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .max_dim  (max_dim_ff),
      .in_valid (!req_empty),
      .in_data  (req_head),
      .in_take  (req_take),
      .out_push (eng_push),
      .out_data (eng_data),
      .out_full (rsp_full)
   );

   sps_fifo #(.item_type(rsp_type), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (eng_push),
      .wr_data (eng_data),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      eng_push |-> !rsp_full)
      else $error("result written into a full queue");

   a_take_avail: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !req_empty)
      else $error("byte taken from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (empty && !full))
      else $error("queues not empty after reset");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      (eng_push && (eng_data.status != ST_OK)) |->
         (eng_data.pic_width == 16'd0 && eng_data.set_id == 32'd0))
      else $error("error result carries nonzero fields");

endmodule
